// ===== rtl/core/sized_buffer_pool_with_idle_eviction_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sized buffer pool: assertion macros
// Shared concurrent assertion forms, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef SIZED_BUFFER_POOL_WITH_IDLE_EVICTION_UNIT_DEFINES_SVH
`define SIZED_BUFFER_POOL_WITH_IDLE_EVICTION_UNIT_DEFINES_SVH

// same-cycle implication
`define SBP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbp assertion failed");

// next-cycle implication
`define SBP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbp assertion failed");

`endif

// ===== rtl/core/sbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Sized buffer pool package
// Widths, field codes and control types shared by the pool modules.
// ----------------------------------------------------------------------------
package sbp_pkg;

    localparam int SLOTS_DEF   = 64;
    localparam int CLASSES_DEF = 16;

    localparam int DIM_W    = 13;
    localparam int HANDLE_W = 6;
    localparam int STATUS_W = 3;
    localparam int KIND_W   = 2;
    localparam int LIMIT_W  = 16;
    localparam int IDLE_W   = 17;

    localparam int S_DATA_W = 32;
    localparam int S_USER_W = KIND_W;
    localparam int M_DATA_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    localparam logic [LIMIT_W-1:0] CLASS_LIMIT_RST = 16'd600;
    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST  = 16'd1200;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GIVE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RETURNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT  = 1'd1;

    // class table commands
    typedef struct packed {
        logic claim;
        logic age;
        logic clear;
    } cls_cmd_t;

    function automatic logic [IDLE_W-1:0] sat_inc(input logic [IDLE_W-1:0] v);
        sat_inc = (v == IDLE_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/core/sbp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/sbp_class_tbl.sv =====
// ----------------------------------------------------------------------------
// Size class table
// Holds the size classes, ages them and marks classes for eviction.
// ----------------------------------------------------------------------------
module sbp_class_tbl #(
    parameter int CLASSES = 16,
    parameter int CW      = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbp_pkg::cls_cmd_t             cmd,
    input  logic [CW-1:0]                 rd_idx,
    output logic                          rd_valid,
    output logic [sbp_pkg::DIM_W-1:0]     rd_w,
    output logic [sbp_pkg::DIM_W-1:0]     rd_h,
    input  logic [CW-1:0]                 wr_idx,
    input  logic [sbp_pkg::DIM_W-1:0]     wr_w,
    input  logic [sbp_pkg::DIM_W-1:0]     wr_h,
    input  logic [CLASSES-1:0]            busy_mask,
    input  logic [sbp_pkg::LIMIT_W-1:0]   idle_limit,
    output logic [CLASSES-1:0]            evict_mask
);
    import sbp_pkg::*;

    logic [CLASSES-1:0] valid_reg, valid_next;
    logic [IDLE_W-1:0]  idle_reg [CLASSES];
    logic [IDLE_W-1:0]  idle_next [CLASSES];
    logic [CLASSES-1:0] evict_reg, evict_next;
    logic [DIM_W-1:0]   w_reg [CLASSES];
    logic [DIM_W-1:0]   h_reg [CLASSES];
    logic [IDLE_W-1:0]  aged;

    assign rd_valid   = valid_reg[rd_idx];
    assign rd_w       = w_reg[rd_idx];
    assign rd_h       = h_reg[rd_idx];
    assign evict_mask = evict_reg;

    // claim, clear and the aging round over all classes
    always_comb
    begin
        valid_next = valid_reg;
        idle_next  = idle_reg;
        evict_next = evict_reg;
        aged       = '0;
        if (cmd.clear)
        begin
            valid_next = '0;
        end
        else if (cmd.claim)
        begin
            valid_next[wr_idx] = 1'b1;
            idle_next[wr_idx]  = '0;
        end
        else if (cmd.age)
        begin
            for (int c = 0; c < CLASSES; c++)
            begin
                aged          = busy_mask[c] ? '0 : sat_inc(idle_reg[c]);
                evict_next[c] = valid_reg[c] && !busy_mask[c] &&
                                (aged > IDLE_W'(idle_limit));
                if (valid_reg[c])
                begin
                    idle_next[c] = evict_next[c] ? '0 : aged;
                end
                if (evict_next[c])
                begin
                    valid_next[c] = 1'b0;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            evict_reg <= '0;
            for (int c = 0; c < CLASSES; c++)
            begin
                idle_reg[c] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            evict_reg <= evict_next;
            idle_reg  <= idle_next;
        end
    end

    // class sizes
    always_ff @(posedge clk)
    begin
        if (cmd.claim && !cmd.clear)
        begin
            w_reg[wr_idx] <= wr_w;
            h_reg[wr_idx] <= wr_h;
        end
    end

endmodule

// ===== rtl/core/sized_buffer_pool_with_idle_eviction_unit.sv =====
// ----------------------------------------------------------------------------
// Sized buffer pool with idle eviction
// Slot allocator keyed by buffer size, with idle ageing and eviction.
// ----------------------------------------------------------------------------
// One request at a time. For a get the class table is searched one entry a
// cycle, then the slot memories are walked one slot a cycle twice, once to
// find a slot and once to age and evict, since slot class and idle counts
// sit in RAMs with a single read port. A give-back, a clear or an unused
// kind goes straight to the response. The result is held in an output
// register; the next request is taken while it waits.
`include "sized_buffer_pool_with_idle_eviction_unit_defines.svh"

module sized_buffer_pool_with_idle_eviction_unit #(
    parameter int SLOTS   = sbp_pkg::SLOTS_DEF,
    parameter int CLASSES = sbp_pkg::CLASSES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [12:0] req_width, [25:13] req_height, [31:26] handle_in
    input  logic [sbp_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [sbp_pkg::S_USER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] handle_out, [8:6] status, [15:9] zero
    output logic [sbp_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbp_pkg::LIMIT_W-1:0]     cfg_data
);
    import sbp_pkg::*;

    localparam int SW   = $clog2(SLOTS);
    localparam int CW   = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int MAXN = (SLOTS > CLASSES) ? SLOTS : CLASSES;
    localparam int CNTW = $clog2(MAXN + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CSCAN = 7'b0000010,
        S_SSCAN = 7'b0000100,
        S_CLAIM = 7'b0001000,
        S_CAGE  = 7'b0010000,
        S_SPASS = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic [DIM_W-1:0]   req_w_reg, req_w_next, req_h_reg, req_h_next;
    logic               match_f_reg, match_f_next, ecls_f_reg, ecls_f_next;
    logic [CW-1:0]      match_reg, match_next, ecls_reg, ecls_next;
    logic               free_f_reg, free_f_next, empty_f_reg, empty_f_next;
    logic [SW-1:0]      free_reg, free_next, empty_reg, empty_next;
    logic [CLASSES-1:0] busy_mask_reg, busy_mask_next;
    logic [SLOTS-1:0]   valid_reg, valid_next, busy_reg, busy_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [LIMIT_W-1:0] cls_limit_reg, slot_limit_reg;

    // request fields
    logic [DIM_W-1:0]    in_w, in_h;
    logic [HANDLE_W-1:0] in_hdl;
    logic                hdl_ok;
    logic [SW-1:0]       hdl_idx;
    logic [SW-1:0]       p_idx;

    // slot memories
    logic               cls_we, idle_we;
    logic [SW-1:0]      cls_waddr, idle_waddr;
    logic [CW-1:0]      cls_wdata, cls_rdata;
    logic [IDLE_W-1:0]  idle_wdata, idle_rdata, idle_aged;

    // class table link
    cls_cmd_t           ccmd;
    logic               crd_valid;
    logic [DIM_W-1:0]   crd_w, crd_h;
    logic [CLASSES-1:0] evict_mask;

    assign in_w     = s_tdata[12:0];
    assign in_h     = s_tdata[25:13];
    assign in_hdl   = s_tdata[31:26];
    assign hdl_ok   = 32'(in_hdl) < 32'(SLOTS);
    assign hdl_idx  = SW'(in_hdl);
    assign p_idx    = SW'(cnt_reg - 1'b1);
    assign idle_aged = busy_reg[p_idx] ? '0 : sat_inc(idle_rdata);

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    sbp_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_cls_ram (
        .clk   (clk),
        .we    (cls_we),
        .waddr (cls_waddr),
        .wdata (cls_wdata),
        .raddr (cnt_reg[SW-1:0]),
        .rdata (cls_rdata)
    );

    sbp_ram #(.WIDTH(IDLE_W), .DEPTH(SLOTS)) u_idle_ram (
        .clk   (clk),
        .we    (idle_we),
        .waddr (idle_waddr),
        .wdata (idle_wdata),
        .raddr (cnt_reg[SW-1:0]),
        .rdata (idle_rdata)
    );

    sbp_class_tbl #(.CLASSES(CLASSES), .CW(CW)) u_class_tbl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ccmd),
        .rd_idx     (cnt_reg[CW-1:0]),
        .rd_valid   (crd_valid),
        .rd_w       (crd_w),
        .rd_h       (crd_h),
        .wr_idx     (ecls_reg),
        .wr_w       (req_w_reg),
        .wr_h       (req_h_reg),
        .busy_mask  (busy_mask_reg),
        .idle_limit (cls_limit_reg),
        .evict_mask (evict_mask)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        req_w_next      = req_w_reg;
        req_h_next      = req_h_reg;
        match_f_next    = match_f_reg;
        match_next      = match_reg;
        ecls_f_next     = ecls_f_reg;
        ecls_next       = ecls_reg;
        free_f_next     = free_f_reg;
        free_next       = free_reg;
        empty_f_next    = empty_f_reg;
        empty_next      = empty_reg;
        busy_mask_next  = busy_mask_reg;
        valid_next      = valid_reg;
        busy_next       = busy_reg;
        res_handle_next = res_handle_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        cls_we          = 1'b0;
        cls_waddr       = empty_reg;
        cls_wdata       = match_reg;
        idle_we         = 1'b0;
        idle_waddr      = p_idx;
        idle_wdata      = '0;
        ccmd            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_w_next      = in_w;
                    req_h_next      = in_h;
                    cnt_next        = '0;
                    res_handle_next = '0;
                    case (s_tuser)
                        KIND_GET:
                        begin
                            match_f_next   = 1'b0;
                            ecls_f_next    = 1'b0;
                            free_f_next    = 1'b0;
                            empty_f_next   = 1'b0;
                            busy_mask_next = '0;
                            state_next     = S_CSCAN;
                        end
                        KIND_GIVE:
                        begin
                            if (hdl_ok && valid_reg[hdl_idx])
                            begin
                                busy_next[hdl_idx] = 1'b0;
                                idle_we            = 1'b1;
                                idle_waddr         = hdl_idx;
                                res_status_next    = ST_RETURNED;
                            end
                            else
                            begin
                                res_status_next = ST_UNKNOWN;
                            end
                            state_next = S_RESP;
                        end
                        KIND_CLEAR:
                        begin
                            valid_next      = '0;
                            busy_next       = '0;
                            ccmd.clear      = 1'b1;
                            res_status_next = ST_CLEARED;
                            state_next      = S_RESP;
                        end
                        default:
                        begin
                            res_status_next = ST_UNKNOWN;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end
            // class search, one entry a cycle
            S_CSCAN:
            begin
                if (crd_valid && crd_w == req_w_reg && crd_h == req_h_reg && !match_f_reg)
                begin
                    match_f_next = 1'b1;
                    match_next   = cnt_reg[CW-1:0];
                end
                if (!crd_valid && !ecls_f_reg)
                begin
                    ecls_f_next = 1'b1;
                    ecls_next   = cnt_reg[CW-1:0];
                end
                if (cnt_reg == CNTW'(CLASSES - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SSCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            // slot search; RAM read data belongs to the previous address
            S_SSCAN:
            begin
                if (cnt_reg != '0)
                begin
                    if (!valid_reg[p_idx] && !empty_f_reg)
                    begin
                        empty_f_next = 1'b1;
                        empty_next   = p_idx;
                    end
                    if (valid_reg[p_idx] && !busy_reg[p_idx] && match_f_reg &&
                        cls_rdata == match_reg && !free_f_reg)
                    begin
                        free_f_next = 1'b1;
                        free_next   = p_idx;
                    end
                    if (valid_reg[p_idx] && busy_reg[p_idx])
                    begin
                        busy_mask_next[cls_rdata] = 1'b1;
                    end
                end
                if (cnt_reg == CNTW'(SLOTS))
                begin
                    state_next = S_CLAIM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            // grant or claim
            S_CLAIM:
            begin
                res_status_next = ST_FULL;
                if (match_f_reg && free_f_reg)
                begin
                    busy_next[free_reg]       = 1'b1;
                    busy_mask_next[match_reg] = 1'b1;
                    res_handle_next           = HANDLE_W'(free_reg);
                    res_status_next           = ST_REUSED;
                end
                else if (empty_f_reg && (match_f_reg || ecls_f_reg))
                begin
                    valid_next[empty_reg] = 1'b1;
                    busy_next[empty_reg]  = 1'b1;
                    cls_we                = 1'b1;
                    idle_we               = 1'b1;
                    idle_waddr            = empty_reg;
                    if (match_f_reg)
                    begin
                        busy_mask_next[match_reg] = 1'b1;
                    end
                    else
                    begin
                        cls_wdata                = ecls_reg;
                        ccmd.claim               = 1'b1;
                        busy_mask_next[ecls_reg] = 1'b1;
                    end
                    res_handle_next = HANDLE_W'(empty_reg);
                    res_status_next = ST_NEW;
                end
                cnt_next   = '0;
                state_next = S_CAGE;
            end
            S_CAGE:
            begin
                ccmd.age   = 1'b1;
                cnt_next   = '0;
                state_next = S_SPASS;
            end
            // slot ageing and eviction
            S_SPASS:
            begin
                if (cnt_reg != '0 && valid_reg[p_idx])
                begin
                    if (evict_mask[cls_rdata] || idle_aged > IDLE_W'(slot_limit_reg))
                    begin
                        valid_next[p_idx] = 1'b0;
                        busy_next[p_idx]  = 1'b0;
                    end
                    else
                    begin
                        idle_we    = 1'b1;
                        idle_wdata = idle_aged;
                    end
                end
                if (cnt_reg == CNTW'(SLOTS))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({res_status_reg, res_handle_reg});
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            busy_reg    <= '0;
            m_valid_reg <= 1'b0;
            match_f_reg <= 1'b0;
            ecls_f_reg  <= 1'b0;
            free_f_reg  <= 1'b0;
            empty_f_reg <= 1'b0;
            busy_mask_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            match_f_reg <= match_f_next;
            ecls_f_reg  <= ecls_f_next;
            free_f_reg  <= free_f_next;
            empty_f_reg <= empty_f_next;
            busy_mask_reg <= busy_mask_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        req_w_reg      <= req_w_next;
        req_h_reg      <= req_h_next;
        match_reg      <= match_next;
        ecls_reg       <= ecls_next;
        free_reg       <= free_next;
        empty_reg      <= empty_next;
        res_handle_reg <= res_handle_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_limit_reg  <= CLASS_LIMIT_RST;
            slot_limit_reg <= SLOT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CLASS_LIMIT: cls_limit_reg  <= cfg_data;
                REG_SLOT_LIMIT:  slot_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // a busy slot is always a live slot
    `SBP_ASSERT_IMP(a_busy_valid, 1'b1, (busy_reg & ~valid_reg) == '0)
    // a class with a busy slot is never evicted
    `SBP_ASSERT_IMP(a_evict_idle, state_reg == S_SPASS, (evict_mask & busy_mask_reg) == '0)
    // an accepted request takes the sequencer out of idle
    `SBP_ASSERT_NXT(a_accept_busy, s_tvalid && s_tready, !s_tready)

endmodule

// ===== verif/tb_sized_buffer_pool_with_idle_eviction_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sized buffer pool testbench
// Drives get, give-back, clear and unused-kind requests over the stream
// port. A behavioural pool model tracks slots, size classes, ageing and
// eviction; each result is checked in order against it or a directed row's
// expectation. The run goes through several idle-limit settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_sized_buffer_pool_with_idle_eviction_unit;
    import sbp_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int NCLS  = CLASSES_DEF;

    typedef struct {
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [HANDLE_W-1:0] hin;
        bit                  typed;
        logic [HANDLE_W-1:0] exp_handle;
        logic [STATUS_W-1:0] exp_status;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [S_USER_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [LIMIT_W-1:0]    cfg_data = '0;

    sized_buffer_pool_with_idle_eviction_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // pool model state
    bit                 slot_used [NSLOT];
    logic [DIM_W-1:0]   slot_w    [NSLOT];
    logic [DIM_W-1:0]   slot_h    [NSLOT];
    bit                 slot_held [NSLOT];
    logic [IDLE_W-1:0]  slot_age  [NSLOT];
    bit                 cls_used  [NCLS];
    logic [DIM_W-1:0]   cls_w     [NCLS];
    logic [DIM_W-1:0]   cls_h     [NCLS];
    logic [IDLE_W-1:0]  cls_age   [NCLS];
    logic [LIMIT_W-1:0] cls_limit  = CLASS_LIMIT_RST;
    logic [LIMIT_W-1:0] slot_limit = SLOT_LIMIT_RST;

    result_t pending_results[$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    function automatic bit slot_of_class(int s, int c);
        return slot_used[s] && slot_w[s] == cls_w[c] && slot_h[s] == cls_h[c];
    endfunction

    function automatic bit class_in_use(int c);
        for (int s = 0; s < NSLOT; s++)
            if (slot_of_class(s, c) && slot_held[s])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void drop_slot(int s);
        slot_used[s] = 1'b0;
        slot_held[s] = 1'b0;
        slot_age[s]  = '0;
    endfunction

    // ageing, then class eviction, then slot eviction
    function automatic void age_pool();
        for (int c = 0; c < NCLS; c++)
            if (cls_used[c])
                cls_age[c] = class_in_use(c) ? '0 :
                             (cls_age[c] == IDLE_MAX ? cls_age[c] : cls_age[c] + 1'b1);
        for (int s = 0; s < NSLOT; s++)
            if (slot_used[s])
                slot_age[s] = slot_held[s] ? '0 :
                              (slot_age[s] == IDLE_MAX ? slot_age[s] : slot_age[s] + 1'b1);
        for (int c = 0; c < NCLS; c++)
        begin
            if (!cls_used[c] || cls_age[c] <= {1'b0, cls_limit} || class_in_use(c))
                continue;
            for (int s = 0; s < NSLOT; s++)
                if (slot_of_class(s, c))
                    drop_slot(s);
            cls_used[c] = 1'b0;
            cls_age[c]  = '0;
        end
        for (int s = 0; s < NSLOT; s++)
            if (slot_used[s] && slot_age[s] > {1'b0, slot_limit})
                drop_slot(s);
    endfunction

    function automatic int first_free_slot();
        for (int s = 0; s < NSLOT; s++)
            if (!slot_used[s])
                return s;
        return -1;
    endfunction

    function automatic void take_slot(int s, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        slot_used[s] = 1'b1;
        slot_w[s]    = w;
        slot_h[s]    = h;
        slot_held[s] = 1'b1;
        slot_age[s]  = '0;
    endfunction

    function automatic result_t pool_step(logic [KIND_W-1:0] kind, logic [DIM_W-1:0] w,
                                          logic [DIM_W-1:0] h, logic [HANDLE_W-1:0] hin);
        result_t r;
        int cls;
        int got;
        r.handle = '0;
        r.status = ST_UNKNOWN;
        cls = -1;
        got = -1;
        if (kind == KIND_GET)
        begin
            for (int c = 0; c < NCLS && cls < 0; c++)
                if (cls_used[c] && cls_w[c] == w && cls_h[c] == h)
                    cls = c;
            if (cls >= 0)
            begin
                for (int s = 0; s < NSLOT && got < 0; s++)
                    if (slot_of_class(s, cls) && !slot_held[s])
                        got = s;
                if (got >= 0)
                begin
                    slot_held[got] = 1'b1;
                    r.status = ST_REUSED;
                end
                else
                begin
                    got = first_free_slot();
                    if (got >= 0)
                    begin
                        take_slot(got, w, h);
                        r.status = ST_NEW;
                    end
                    else
                        r.status = ST_FULL;
                end
            end
            else
            begin
                for (int c = 0; c < NCLS && cls < 0; c++)
                    if (!cls_used[c])
                        cls = c;
                got = first_free_slot();
                if (cls >= 0 && got >= 0)
                begin
                    cls_used[cls] = 1'b1;
                    cls_w[cls]    = w;
                    cls_h[cls]    = h;
                    cls_age[cls]  = '0;
                    take_slot(got, w, h);
                    r.status = ST_NEW;
                end
                else
                begin
                    got = -1;
                    r.status = ST_FULL;
                end
            end
            if (got >= 0)
                r.handle = got[HANDLE_W-1:0];
            age_pool();
        end
        else if (kind == KIND_GIVE)
        begin
            if (slot_used[hin])
            begin
                slot_held[hin] = 1'b0;
                slot_age[hin]  = '0;
                r.status = ST_RETURNED;
            end
        end
        else if (kind == KIND_CLEAR)
        begin
            for (int s = 0; s < NSLOT; s++)
                drop_slot(s);
            for (int c = 0; c < NCLS; c++)
            begin
                cls_used[c] = 1'b0;
                cls_age[c]  = '0;
            end
            r.status = ST_CLEARED;
        end
        return r;
    endfunction

    // receiver stalls
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // result checking
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result handle=%0d status=%0d",
                             m_tdata[5:0], m_tdata[8:6]);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[5:0] !== want.handle || m_tdata[8:6] !== want.status
                    || m_tdata[15:9] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp handle=%0d status=%0d, got data=%h",
                                 want.handle, want.status, m_tdata);
                end
            end
        end
    end

    // one request on the stream port; the expectation is queued on acceptance
    task automatic send_request(row_t rq);
        result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= rq.kind;
        s_tdata  <= {rq.hin, rq.h, rq.w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = pool_step(rq.kind, rq.w, rq.h, rq.hin);
        if (rq.typed)
        begin
            r.handle = rq.exp_handle;
            r.status = rq.exp_status;
        end
        pending_results.push_back(r);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
        @(negedge clk);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_CLASS_LIMIT)
            cls_limit = val;
        else
            slot_limit = val;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * NSLOT + NCLS + 20) @(posedge clk);
    endtask

    // timeout
    initial
    begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        row_t directed[$];
        row_t rq;
        logic [DIM_W-1:0] sizes_w[24];
        logic [DIM_W-1:0] sizes_h[24];
        int pick;
        int plan_cls[5];
        int plan_slot[5];
        int plan_send[5];
        int plan_stall[5];

        plan_cls   = '{0, 65535, 3, 20, 600};
        plan_slot  = '{0, 65535, 10, 5, 1200};
        plan_send  = '{0, 53, 0, 6, 25};
        plan_stall = '{0, 0, 53, 6, 25};

        // after reset, extremes, every kind and repeated give-back
        directed = '{
            '{KIND_GIVE,   13'd0,    13'd0,    6'd5,  1'b1, 6'd0, ST_UNKNOWN},
            '{KIND_GET,    13'd0,    13'd0,    6'd0,  1'b1, 6'd0, ST_NEW},
            '{KIND_GET,    13'd8191, 13'd8191, 6'd0,  1'b1, 6'd1, ST_NEW},
            '{KIND_GET,    13'd0,    13'd0,    6'd0,  1'b1, 6'd2, ST_NEW},
            '{KIND_GIVE,   13'd0,    13'd0,    6'd0,  1'b1, 6'd0, ST_RETURNED},
            '{KIND_GIVE,   13'd0,    13'd0,    6'd0,  1'b1, 6'd0, ST_RETURNED},
            '{KIND_GET,    13'd0,    13'd0,    6'd0,  1'b1, 6'd0, ST_REUSED},
            '{KIND_GIVE,   13'd0,    13'd0,    6'd63, 1'b1, 6'd0, ST_UNKNOWN},
            '{KIND_UNUSED, 13'd8191, 13'd8191, 6'd63, 1'b1, 6'd0, ST_UNKNOWN},
            '{KIND_GET,    13'd8191, 13'd0,    6'd0,  1'b0, 6'd0, ST_REUSED},
            '{KIND_GET,    13'd0,    13'd8191, 6'd0,  1'b0, 6'd0, ST_REUSED},
            '{KIND_GIVE,   13'd0,    13'd0,    6'd1,  1'b0, 6'd0, ST_REUSED},
            '{KIND_GET,    13'd8191, 13'd8191, 6'd0,  1'b0, 6'd0, ST_REUSED},
            '{KIND_GIVE,   13'd0,    13'd0,    6'd42, 1'b0, 6'd0, ST_REUSED},
            '{KIND_CLEAR,  13'd0,    13'd0,    6'd0,  1'b1, 6'd0, ST_CLEARED},
            '{KIND_GIVE,   13'd0,    13'd0,    6'd0,  1'b1, 6'd0, ST_UNKNOWN},
            '{KIND_GET,    13'd1,    13'd1,    6'd0,  1'b1, 6'd0, ST_NEW},
            '{KIND_GET,    13'd4096, 13'd2730, 6'd0,  1'b0, 6'd0, ST_REUSED},
            '{KIND_GIVE,   13'd0,    13'd0,    6'd21, 1'b0, 6'd0, ST_REUSED}
        };

        // size set: corners plus random sizes, more than there are classes
        for (int i = 0; i < 24; i++)
        begin
            sizes_w[i] = DIM_W'($urandom_range(0, 8191));
            sizes_h[i] = DIM_W'($urandom_range(0, 8191));
        end
        sizes_w[0] = 13'd0;    sizes_h[0] = 13'd8191;
        sizes_w[1] = 13'd8191; sizes_h[1] = 13'd0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_request(directed[i]);
        drain();

        // random phases, each with its own limits and idling pattern
        for (int p = 0; p < 5; p++)
        begin
            write_limit(REG_CLASS_LIMIT, LIMIT_W'(plan_cls[p]));
            write_limit(REG_SLOT_LIMIT, LIMIT_W'(plan_slot[p]));
            send_idle_pct  = plan_send[p];
            recv_stall_pct = plan_stall[p];
            repeat (390)
            begin
                pick = $urandom_range(0, 99);
                rq.typed = 1'b0;
                rq.exp_handle = '0;
                rq.exp_status = ST_UNKNOWN;
                rq.w   = DIM_W'($urandom_range(0, 8191));
                rq.h   = DIM_W'($urandom_range(0, 8191));
                rq.hin = HANDLE_W'($urandom_range(0, NSLOT - 1));
                if (pick < 65)
                begin
                    rq.kind = KIND_GET;
                    if ($urandom_range(0, 9) != 0)
                    begin
                        pick = $urandom_range(0, (p == 1) ? 23 : 11);
                        rq.w = sizes_w[pick];
                        rq.h = sizes_h[pick];
                    end
                end
                else if (pick < 93)
                    rq.kind = KIND_GIVE;
                else if (pick < 95)
                    rq.kind = KIND_CLEAR;
                else
                    rq.kind = KIND_UNUSED;
                send_request(rq);
            end
            drain();
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
